// ----- sv/number_redirect_table_unit_defines.svh -----
// Assertion macros for the number redirect table unit.
`ifndef NUMBER_REDIRECT_TABLE_UNIT_DEFINES_SVH
`define NUMBER_REDIRECT_TABLE_UNIT_DEFINES_SVH
`ifndef SYNTH
`define NRT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define NRT_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NRT_ASSERT(label, clk, rst_n, prop, msg)
`define NRT_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// ----- sv/nrt_pkg.sv -----
// Package for the number redirect table unit: codes, widths and helpers.
package nrt_pkg;

  localparam int MaxDigits = 15;
  localparam int TableEntries = 256;
  localparam int MapSlots = 8;
  localparam int KeyW = 64;

  typedef enum logic [2:0] {
    K_CLAIM = 3'd0, K_FREE = 3'd1, K_INSERT = 3'd2, K_ERASE = 3'd3, K_XFORM = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_NOMAP = 3'd1, ST_BADNUM = 3'd2, ST_FULL = 3'd3, ST_NOSLOT = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_WRITE, S_CLEAR, S_DONE
  } state_t;

  // Valid number check; invalid returns ok=0.
  function automatic logic num_ok(input logic [59:0] digits, input logic [3:0] len,
                                  input logic [3:0] max_len);
    logic ok;
    ok = (len != 4'd0) && (len <= max_len);
    for (int i = 0; i < 15; i++) begin
      if ((i < len) && (digits[4*i +: 4] > 4'd9)) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic logic [63:0] num_pack(input logic [59:0] digits, input logic [3:0] len);
    logic [59:0] kept;
    kept = '0;
    for (int i = 0; i < 15; i++) begin
      if (i < len) kept[4*i +: 4] = digits[4*i +: 4];
    end
    return {len, kept};
  endfunction

endpackage

// ----- sv/number_redirect_table_unit.sv -----
// Top level of the number redirect table unit.
// One transaction at a time. Claim and error results need no scan; insert and
// erase scan the shared entry memory once; free sweeps it once to drop the slot's
// entries; transform rescans it for every hop of the chain, up to TABLE_ENTRIES + 1
// scans in all when a loop is found. The entry memory has a single read port.
// No clearing pass follows reset.
module number_redirect_table_unit #(
  parameter int MAX_DIGITS = nrt_pkg::MaxDigits,
  parameter int TABLE_ENTRIES = nrt_pkg::TableEntries,
  parameter int MAP_SLOTS = nrt_pkg::MapSlots
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_kind,
  input  logic [2:0]  in_map_id,
  input  logic [59:0] in_src_digits,
  input  logic [3:0]  in_src_len,
  input  logic [59:0] in_dst_digits,
  input  logic [3:0]  in_dst_len,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [2:0]  out_new_map_id,
  output logic [59:0] out_result_digits,
  output logic [3:0]  out_result_len,
  output logic        out_cycle_found
);
  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int SW = (MAP_SLOTS > 1) ? $clog2(MAP_SLOTS) : 1;

  logic [AW-1:0] rd_addr, wr_addr, inv_addr;
  logic rd_valid, wr_en, inv_en;
  logic [SW-1:0] rd_owner, wr_owner;
  logic [63:0] rd_key, rd_value, wr_key, wr_value;

  nrt_store #(.ENTRIES(TABLE_ENTRIES), .SLOTS(MAP_SLOTS)) u_store (
    .clk, .rst_n, .rd_addr, .rd_valid, .rd_owner, .rd_key, .rd_value,
    .wr_en, .wr_addr, .wr_owner, .wr_key, .wr_value, .inv_en, .inv_addr
  );

  nrt_ctrl #(.ENTRIES(TABLE_ENTRIES), .SLOTS(MAP_SLOTS), .MAX_DIGITS(MAX_DIGITS)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_kind, .in_map_id, .in_src_digits,
    .in_src_len, .in_dst_digits, .in_dst_len, .out_valid, .out_ready, .out_status,
    .out_new_map_id, .out_result_digits, .out_result_len, .out_cycle_found,
    .rd_addr, .rd_valid, .rd_owner, .rd_key, .rd_value,
    .wr_en, .wr_addr, .wr_owner, .wr_key, .wr_value, .inv_en, .inv_addr
  );
endmodule

// ----- sv/nrt_store.sv -----
// Entry store: owner/key/value memory with one registered read port, plus valid flags.
module nrt_store #(
  parameter int ENTRIES = nrt_pkg::TableEntries,
  parameter int SLOTS = nrt_pkg::MapSlots,
  localparam int AW = $clog2(ENTRIES),
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [AW-1:0]        rd_addr,
  output logic                 rd_valid,
  output logic [SW-1:0]        rd_owner,
  output logic [63:0]          rd_key,
  output logic [63:0]          rd_value,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic [SW-1:0]        wr_owner,
  input  logic [63:0]          wr_key,
  input  logic [63:0]          wr_value,
  input  logic                 inv_en,
  input  logic [AW-1:0]        inv_addr
);
  logic [SW+127:0] mem [ENTRIES];
  logic [ENTRIES-1:0] valid_r;
  logic [SW+127:0] rd_data_r;
  logic rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= {wr_owner, wr_key, wr_value};
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) valid_r[wr_addr] <= 1'b1;
      if (inv_en) valid_r[inv_addr] <= 1'b0;
      rd_valid_r <= valid_r[rd_addr] && !(wr_en && wr_addr == rd_addr)
                    && !(inv_en && inv_addr == rd_addr);
    end
  end

  assign rd_valid = rd_valid_r;
  assign {rd_owner, rd_key, rd_value} = rd_data_r;
endmodule

// ----- sv/nrt_ctrl.sv -----
// Sequencer: scans the entry store once per lookup and runs each operation.
`include "number_redirect_table_unit_defines.svh"
module nrt_ctrl #(
  parameter int ENTRIES = nrt_pkg::TableEntries,
  parameter int SLOTS = nrt_pkg::MapSlots,
  parameter int MAX_DIGITS = nrt_pkg::MaxDigits,
  localparam int AW = $clog2(ENTRIES),
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [2:0]    in_kind,
  input  logic [2:0]    in_map_id,
  input  logic [59:0]   in_src_digits,
  input  logic [3:0]    in_src_len,
  input  logic [59:0]   in_dst_digits,
  input  logic [3:0]    in_dst_len,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [2:0]    out_status,
  output logic [2:0]    out_new_map_id,
  output logic [59:0]   out_result_digits,
  output logic [3:0]    out_result_len,
  output logic          out_cycle_found,
  output logic [AW-1:0] rd_addr,
  input  logic          rd_valid,
  input  logic [SW-1:0] rd_owner,
  input  logic [63:0]   rd_key,
  input  logic [63:0]   rd_value,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [SW-1:0] wr_owner,
  output logic [63:0]   wr_key,
  output logic [63:0]   wr_value,
  output logic          inv_en,
  output logic [AW-1:0] inv_addr
);
  localparam logic [3:0] MaxLen = 4'(MAX_DIGITS);
  localparam int CW = $clog2(ENTRIES + 2);

  nrt_pkg::state_t state_r, state_nxt;
  logic [SLOTS-1:0] slot_use_r, slot_use_nxt;
  logic [2:0]  kind_r, kind_nxt;
  logic [SW-1:0] id_r, id_nxt;
  logic [63:0] src_r, src_nxt, dst_r, dst_nxt, cur_r, cur_nxt;
  logic [AW:0] idx_r, idx_nxt;      // address issued, extra bit marks scan end
  logic        chk_r, chk_nxt;      // read data of previous address is due
  logic [AW-1:0] chk_addr_r, chk_addr_nxt;
  logic        hit_r, hit_nxt, fre_r, fre_nxt;
  logic [AW-1:0] hit_addr_r, hit_addr_nxt, fre_addr_r, fre_addr_nxt;
  logic [CW-1:0] hops_r, hops_nxt;
  logic [2:0]  st_r, st_nxt, nid_r, nid_nxt;
  logic [63:0] res_r, res_nxt;
  logic        cyc_r, cyc_nxt;

  logic map_ok, match, src_good, dst_good;
  logic [SW-1:0] in_id;
  logic [SW-1:0] free_slot;
  logic        any_free;

  assign in_id = SW'(in_map_id);
  assign map_ok = ({29'd0, in_map_id} < SLOTS) && slot_use_r[in_id];
  assign src_good = nrt_pkg::num_ok(in_src_digits, in_src_len, MaxLen);
  assign dst_good = nrt_pkg::num_ok(in_dst_digits, in_dst_len, MaxLen);
  assign match = rd_valid && rd_owner == id_r && rd_key == cur_r;

  always_comb begin
    free_slot = '0;
    any_free = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!slot_use_r[i]) begin
        free_slot = SW'(i);
        any_free = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nrt_pkg::S_IDLE;
      slot_use_r <= '0;
    end else begin
      state_r <= state_nxt;
      slot_use_r <= slot_use_nxt;
    end
    kind_r <= kind_nxt; id_r <= id_nxt; src_r <= src_nxt; dst_r <= dst_nxt;
    cur_r <= cur_nxt; idx_r <= idx_nxt; chk_r <= chk_nxt; chk_addr_r <= chk_addr_nxt;
    hit_r <= hit_nxt; fre_r <= fre_nxt; hit_addr_r <= hit_addr_nxt;
    fre_addr_r <= fre_addr_nxt; hops_r <= hops_nxt; st_r <= st_nxt; nid_r <= nid_nxt;
    res_r <= res_nxt; cyc_r <= cyc_nxt;
  end

  always_comb begin
    state_nxt = state_r; slot_use_nxt = slot_use_r;
    kind_nxt = kind_r; id_nxt = id_r; src_nxt = src_r; dst_nxt = dst_r; cur_nxt = cur_r;
    idx_nxt = idx_r; chk_nxt = 1'b0; chk_addr_nxt = chk_addr_r;
    hit_nxt = hit_r; fre_nxt = fre_r; hit_addr_nxt = hit_addr_r; fre_addr_nxt = fre_addr_r;
    hops_nxt = hops_r; st_nxt = st_r; nid_nxt = nid_r; res_nxt = res_r; cyc_nxt = cyc_r;
    in_ready = 1'b0; out_valid = 1'b0;
    rd_addr = idx_r[AW-1:0];
    wr_en = 1'b0; wr_addr = fre_addr_r; wr_owner = id_r; wr_key = src_r; wr_value = dst_r;
    inv_en = 1'b0; inv_addr = hit_addr_r;
    case (state_r)
      nrt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          kind_nxt = in_kind; id_nxt = in_id;
          src_nxt = nrt_pkg::num_pack(in_src_digits, in_src_len);
          dst_nxt = nrt_pkg::num_pack(in_dst_digits, in_dst_len);
          cur_nxt = nrt_pkg::num_pack(in_src_digits, in_src_len);
          idx_nxt = '0; hit_nxt = 1'b0; fre_nxt = 1'b0; hops_nxt = '0;
          st_nxt = nrt_pkg::ST_OK; nid_nxt = '0; res_nxt = '0; cyc_nxt = 1'b0;
          state_nxt = nrt_pkg::S_DONE;
          case (in_kind)
            nrt_pkg::K_CLAIM: begin
              if (any_free) begin
                slot_use_nxt[free_slot] = 1'b1;
                nid_nxt = 3'(free_slot);
              end else begin
                st_nxt = nrt_pkg::ST_NOSLOT;
              end
            end
            nrt_pkg::K_FREE, nrt_pkg::K_INSERT, nrt_pkg::K_ERASE, nrt_pkg::K_XFORM: begin
              if (!map_ok) st_nxt = nrt_pkg::ST_NOMAP;
              else if (in_kind == nrt_pkg::K_FREE) begin
                slot_use_nxt[in_id] = 1'b0;
                state_nxt = nrt_pkg::S_CLEAR;
              end else if (!src_good || (in_kind == nrt_pkg::K_INSERT && !dst_good))
                st_nxt = nrt_pkg::ST_BADNUM;
              else state_nxt = nrt_pkg::S_SCAN;
            end
            default: ;
          endcase
        end
      end
      nrt_pkg::S_SCAN, nrt_pkg::S_CLEAR: begin
        // Issue one read per cycle until the scan ends or, in a scan, a match is seen; check the entry read last cycle.
        if (!idx_r[AW] && !(state_r == nrt_pkg::S_SCAN && chk_r && match)) begin
          chk_nxt = 1'b1; chk_addr_nxt = idx_r[AW-1:0];
          idx_nxt = (idx_r[AW-1:0] == AW'(ENTRIES - 1)) ? {1'b1, {AW{1'b0}}} : idx_r + 1'b1;
        end
        if (state_r == nrt_pkg::S_CLEAR) begin
          if (chk_r && rd_valid && rd_owner == id_r) begin
            inv_en = 1'b1; inv_addr = chk_addr_r;
          end
          if (idx_r[AW] && !chk_r) state_nxt = nrt_pkg::S_DONE;
        end else if (chk_r && match) begin
          hit_nxt = 1'b1; hit_addr_nxt = chk_addr_r;
          chk_nxt = 1'b0;
          if (kind_r == nrt_pkg::K_XFORM) begin
            // Follow the redirection and restart the scan.
            cur_nxt = rd_value; idx_nxt = '0; hops_nxt = hops_r + 1'b1;
            if (hops_r == CW'(ENTRIES)) begin
              cyc_nxt = 1'b1; res_nxt = src_r; state_nxt = nrt_pkg::S_DONE;
            end
          end else state_nxt = nrt_pkg::S_WRITE;
        end else begin
          if (chk_r && !rd_valid && !fre_r) begin
            fre_nxt = 1'b1; fre_addr_nxt = chk_addr_r;
          end
          if (idx_r[AW] && !chk_r) begin
            if (kind_r == nrt_pkg::K_XFORM) begin
              res_nxt = cur_r; state_nxt = nrt_pkg::S_DONE;
            end else if (kind_r == nrt_pkg::K_INSERT) state_nxt = nrt_pkg::S_WRITE;
            else state_nxt = nrt_pkg::S_DONE;
          end
        end
      end
      nrt_pkg::S_WRITE: begin
        state_nxt = nrt_pkg::S_DONE;
        if (kind_r == nrt_pkg::K_ERASE) inv_en = 1'b1;
        else if (hit_r) begin
          wr_en = 1'b1; wr_addr = hit_addr_r;
        end else if (fre_r) wr_en = 1'b1;
        else st_nxt = nrt_pkg::ST_FULL;
      end
      nrt_pkg::S_DONE: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = nrt_pkg::S_IDLE;
      end
      default: state_nxt = nrt_pkg::S_IDLE;
    endcase
  end

  assign out_status = st_r;
  assign out_new_map_id = nid_r;
  assign out_result_digits = res_r[59:0];
  assign out_result_len = res_r[63:60];
  assign out_cycle_found = cyc_r;

  `NRT_ASSERT(a_busy_no_ready, clk, rst_n, (state_r != nrt_pkg::S_IDLE) |-> !in_ready, "ready while busy")
  `NRT_ASSERT(a_wr_inv_excl, clk, rst_n, !(wr_en && inv_en), "write and invalidate together")
  `NRT_ASSERT(a_cyc_src, clk, rst_n, (out_valid && out_cycle_found) |-> (res_r == src_r), "loop result not source")
  `NRT_ASSERT_RST(a_rst_idle, clk, !rst_n |=> (state_r == nrt_pkg::S_IDLE && slot_use_r == '0), "reset state")
endmodule
